// ----- hdl/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

    // Field widths of the channels
    localparam int ACTION_W    = 2;
    localparam int SIZE_W      = 27;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int BYTES_W     = 32;
    localparam int TOTAL_W     = 28;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REALLOC = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_MEM   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_ADDR = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_LIMIT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REQUEST = 8'd1;
    localparam logic [BYTES_W-1:0]     HEAP_LIMIT_RESET  = 32'd1048576;
    localparam logic [SIZE_W-1:0]      MAX_REQUEST_RESET = 27'd100000000;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Work the back end carries out for one request
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REALLOC,
        OP_ILLEGAL,
        OP_NOP
    } ffba_op_t;

    typedef struct packed {
        ffba_op_t            op;
        logic [SIZE_W-1:0]   size;
        logic [TOTAL_W-1:0]  total;
        logic [ADDR_W-1:0]   addr;
    } ffba_cmd_t;

    // One block of the heap table; the payload address is kept directly
    typedef struct packed {
        logic [ADDR_W-1:0]  paddr;
        logic [SIZE_W-1:0]  size;
        logic               free;
    } ffba_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ffba_qstat_t;

endpackage

// ----- hdl/ffba_req_if.sv -----
`timescale 1ns / 1ps

interface ffba_req_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::ACTION_W-1:0]  action;
    logic [ffba_pkg::SIZE_W-1:0]    request_size;
    logic [ffba_pkg::ADDR_W-1:0]    block_address;

    modport source (output valid, output action, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input action, input request_size,
                    input block_address, output ready);
endinterface

// ----- hdl/ffba_rsp_if.sv -----
`timescale 1ns / 1ps

interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::ADDR_W-1:0]    result_address;
    logic [ffba_pkg::COUNT_W-1:0]   free_block_count;
    logic [ffba_pkg::BYTES_W-1:0]   free_byte_count;
    logic [ffba_pkg::COUNT_W-1:0]   block_count;
    logic [ffba_pkg::BYTES_W-1:0]   payload_byte_count;

    modport source (output valid, output status, output result_address,
                    output free_block_count, output free_byte_count,
                    output block_count, output payload_byte_count, input ready);
    modport sink   (input valid, input status, input result_address,
                    input free_block_count, input free_byte_count,
                    input block_count, input payload_byte_count, output ready);
endinterface

// ----- hdl/ffba_cfg_if.sv -----
`timescale 1ns / 1ps

interface ffba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ffba_pkg::CFG_INDEX_W-1:0]  index;
    logic [ffba_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ffba_front.sv -----
`timescale 1ns / 1ps

module ffba_front #(
    parameter int HEADER_BYTES = 16
) (
    ffba_req_if.sink                        req,
    input  logic [ffba_pkg::SIZE_W-1:0]     max_request,
    input  ffba_pkg::ffba_qstat_t           q_stat,
    output logic                            push,
    output ffba_pkg::ffba_cmd_t             push_cmd
);

    logic illegal;

    // Take a request whenever the queue has room
    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full;

    // Classify the request and precompute the block footprint
    always_comb
    begin
        illegal        = (req.request_size == '0) || (req.request_size > max_request);
        push_cmd.size  = req.request_size;
        push_cmd.addr  = req.block_address;
        push_cmd.total = ffba_pkg::TOTAL_W'(req.request_size)
                       + ffba_pkg::TOTAL_W'(HEADER_BYTES);
        unique case (req.action)
            ffba_pkg::ACT_ALLOC:
                push_cmd.op = illegal ? ffba_pkg::OP_ILLEGAL : ffba_pkg::OP_ALLOC;
            ffba_pkg::ACT_FREE:
                push_cmd.op = ffba_pkg::OP_FREE;
            ffba_pkg::ACT_REALLOC:
                push_cmd.op = illegal ? ffba_pkg::OP_ILLEGAL : ffba_pkg::OP_REALLOC;
            default:
                push_cmd.op = ffba_pkg::OP_NOP;
        endcase
    end

endmodule

// ----- hdl/ffba_queue.sv -----
`timescale 1ns / 1ps

module ffba_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ffba_pkg::ffba_cmd_t     push_cmd,
    input  logic                    pop,
    output ffba_pkg::ffba_cmd_t     pop_cmd,
    output ffba_pkg::ffba_qstat_t   q_stat
);

    ffba_pkg::ffba_cmd_t             slot_reg [ffba_pkg::QDEPTH];
    logic [ffba_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ffba_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ffba_pkg::QCNT_W-1:0]     cnt_reg;

    assign q_stat.full  = (cnt_reg == ffba_pkg::QCNT_W'(ffba_pkg::QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/ffba_engine.sv -----
`timescale 1ns / 1ps

module ffba_engine #(
    parameter int MAX_ENTRIES  = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ffba_pkg::BYTES_W-1:0]    heap_limit,
    input  ffba_pkg::ffba_qstat_t           q_stat,
    input  ffba_pkg::ffba_cmd_t             pop_cmd,
    output logic                            pop,
    ffba_rsp_if.source                      rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_RELEASE,
        S_DONE
    } state_t;

    // Heap table
    ffba_pkg::ffba_entry_t  mem [MAX_ENTRIES];
    ffba_pkg::ffba_entry_t  rd_data_reg;
    logic [IDX_W-1:0]       rd_idx;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    ffba_pkg::ffba_entry_t  wr_data;

    state_t                             state_reg;
    ffba_pkg::ffba_op_t                 op_reg;
    logic [ffba_pkg::SIZE_W-1:0]        size_reg;
    logic [ffba_pkg::TOTAL_W-1:0]       total_reg;
    logic [ffba_pkg::ADDR_W-1:0]        addr_reg;
    logic                               fit_mode_reg;
    logic [CNT_W-1:0]                   scan_idx_reg;
    logic [IDX_W-1:0]                   cmp_idx_reg;
    logic                               cmp_vld_reg;
    logic [IDX_W-1:0]                   old_idx_reg;
    ffba_pkg::ffba_entry_t              old_entry_reg;
    logic [ffba_pkg::STATUS_W-1:0]      status_reg;
    logic [ffba_pkg::ADDR_W-1:0]        result_reg;

    // Running statistics
    logic [CNT_W-1:0]                   used_reg;
    logic [ffba_pkg::BYTES_W-1:0]       heap_top_reg;
    logic [CNT_W-1:0]                   free_blocks_reg;
    logic [ffba_pkg::BYTES_W-1:0]       free_bytes_reg;
    logic [ffba_pkg::BYTES_W-1:0]       payload_bytes_reg;

    // Output register
    logic                               out_vld_reg;
    logic [ffba_pkg::STATUS_W-1:0]      out_status_reg;
    logic [ffba_pkg::ADDR_W-1:0]        out_addr_reg;
    logic [ffba_pkg::COUNT_W-1:0]       out_free_blk_reg;
    logic [ffba_pkg::BYTES_W-1:0]       out_free_bytes_reg;
    logic [ffba_pkg::COUNT_W-1:0]       out_blk_reg;
    logic [ffba_pkg::BYTES_W-1:0]       out_payload_reg;

    logic                               hit;
    logic [ffba_pkg::BYTES_W:0]         end_sum;
    logic                               fits;
    logic [ffba_pkg::ADDR_W-1:0]        new_paddr;
    logic [31:0]                        free_blocks_ext;
    logic [31:0]                        used_ext;

    assign rsp.valid              = out_vld_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.result_address     = out_addr_reg;
    assign rsp.free_block_count   = out_free_blk_reg;
    assign rsp.free_byte_count    = out_free_bytes_reg;
    assign rsp.block_count        = out_blk_reg;
    assign rsp.payload_byte_count = out_payload_reg;

    assign pop             = (state_reg == S_IDLE) && !q_stat.empty;
    assign rd_idx          = scan_idx_reg[IDX_W-1:0];
    assign free_blocks_ext = 32'(free_blocks_reg);
    assign used_ext        = 32'(used_reg);

    // Compare the entry read last cycle and check room for an append
    always_comb
    begin
        if (fit_mode_reg)
        begin
            hit = cmp_vld_reg && rd_data_reg.free && (rd_data_reg.size >= size_reg);
        end
        else
        begin
            hit = cmp_vld_reg && (rd_data_reg.paddr == addr_reg);
        end
        end_sum   = {1'b0, heap_top_reg} + (ffba_pkg::BYTES_W + 1)'(total_reg);
        fits      = (end_sum <= {1'b0, heap_limit}) && (used_reg < CNT_W'(MAX_ENTRIES));
        new_paddr = heap_top_reg + ffba_pkg::ADDR_W'(HEADER_BYTES);
    end

    // Select the table write for the current step
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = cmp_idx_reg;
        wr_data = rd_data_reg;
        case (state_reg)
            S_SCAN:
            begin
                if (hit && (fit_mode_reg || (op_reg == ffba_pkg::OP_FREE)))
                begin
                    wr_en        = fit_mode_reg || !rd_data_reg.free;
                    wr_data.free = !fit_mode_reg;
                end
            end
            S_APPEND:
            begin
                wr_en         = fits;
                wr_idx        = used_reg[IDX_W-1:0];
                wr_data.paddr = new_paddr;
                wr_data.size  = size_reg;
                wr_data.free  = 1'b0;
            end
            S_RELEASE:
            begin
                wr_en        = !old_entry_reg.free;
                wr_idx       = old_idx_reg;
                wr_data      = old_entry_reg;
                wr_data.free = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    // Sequence one command: scan, append, release, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= ffba_pkg::OP_NOP;
            size_reg           <= '0;
            total_reg          <= '0;
            addr_reg           <= '0;
            fit_mode_reg       <= 1'b0;
            scan_idx_reg       <= '0;
            cmp_idx_reg        <= '0;
            cmp_vld_reg        <= 1'b0;
            old_idx_reg        <= '0;
            old_entry_reg      <= '0;
            status_reg         <= ffba_pkg::ST_OK;
            result_reg         <= '0;
            used_reg           <= '0;
            heap_top_reg       <= '0;
            free_blocks_reg    <= '0;
            free_bytes_reg     <= '0;
            payload_bytes_reg  <= '0;
            out_vld_reg        <= 1'b0;
            out_status_reg     <= ffba_pkg::ST_OK;
            out_addr_reg       <= '0;
            out_free_blk_reg   <= '0;
            out_free_bytes_reg <= '0;
            out_blk_reg        <= '0;
            out_payload_reg    <= '0;
        end
        else
        begin
            // Drop the result once it transfers, unless a new one replaces it
            if (out_vld_reg && rsp.ready && (state_reg != S_DONE))
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        op_reg       <= pop_cmd.op;
                        size_reg     <= pop_cmd.size;
                        total_reg    <= pop_cmd.total;
                        addr_reg     <= pop_cmd.addr;
                        fit_mode_reg <= (pop_cmd.op == ffba_pkg::OP_ALLOC);
                        scan_idx_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                        status_reg   <= (pop_cmd.op == ffba_pkg::OP_ILLEGAL)
                                      ? ffba_pkg::ST_ILLEGAL_SIZE : ffba_pkg::ST_OK;
                        result_reg   <= '0;
                        if ((pop_cmd.op == ffba_pkg::OP_NOP)
                            || (pop_cmd.op == ffba_pkg::OP_ILLEGAL))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        cmp_vld_reg <= 1'b0;
                        if (fit_mode_reg)
                        begin
                            // Reuse the first free block that is large enough
                            free_blocks_reg <= free_blocks_reg - CNT_W'(1);
                            free_bytes_reg  <= free_bytes_reg
                                             - ffba_pkg::BYTES_W'(rd_data_reg.size);
                            result_reg      <= rd_data_reg.paddr;
                            state_reg       <= (op_reg == ffba_pkg::OP_REALLOC)
                                             ? S_RELEASE : S_DONE;
                        end
                        else if (op_reg == ffba_pkg::OP_FREE)
                        begin
                            if (!rd_data_reg.free)
                            begin
                                free_blocks_reg <= free_blocks_reg + CNT_W'(1);
                                free_bytes_reg  <= free_bytes_reg
                                                 + ffba_pkg::BYTES_W'(rd_data_reg.size);
                            end
                            state_reg <= S_DONE;
                        end
                        else if (rd_data_reg.size >= size_reg)
                        begin
                            // Block already big enough: keep it
                            result_reg <= addr_reg;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            // Hold the old block and rescan for a new one
                            old_idx_reg   <= cmp_idx_reg;
                            old_entry_reg <= rd_data_reg;
                            fit_mode_reg  <= 1'b1;
                            scan_idx_reg  <= '0;
                        end
                    end
                    else if (scan_idx_reg < used_reg)
                    begin
                        cmp_vld_reg  <= 1'b1;
                        cmp_idx_reg  <= scan_idx_reg[IDX_W-1:0];
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                        if (!cmp_vld_reg)
                        begin
                            if (fit_mode_reg)
                            begin
                                state_reg <= S_APPEND;
                            end
                            else
                            begin
                                status_reg <= ffba_pkg::ST_UNKNOWN_ADDR;
                                state_reg  <= S_DONE;
                            end
                        end
                    end
                end
                S_APPEND:
                begin
                    if (fits)
                    begin
                        used_reg          <= used_reg + CNT_W'(1);
                        heap_top_reg      <= end_sum[ffba_pkg::BYTES_W-1:0];
                        payload_bytes_reg <= payload_bytes_reg
                                           + ffba_pkg::BYTES_W'(size_reg);
                        result_reg        <= new_paddr;
                        state_reg         <= (op_reg == ffba_pkg::OP_REALLOC)
                                           ? S_RELEASE : S_DONE;
                    end
                    else
                    begin
                        status_reg <= ffba_pkg::ST_OUT_OF_MEM;
                        result_reg <= '0;
                        state_reg  <= S_DONE;
                    end
                end
                S_RELEASE:
                begin
                    if (!old_entry_reg.free)
                    begin
                        free_blocks_reg <= free_blocks_reg + CNT_W'(1);
                        free_bytes_reg  <= free_bytes_reg
                                         + ffba_pkg::BYTES_W'(old_entry_reg.size);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_vld_reg || rsp.ready)
                    begin
                        out_vld_reg        <= 1'b1;
                        out_status_reg     <= status_reg;
                        out_addr_reg       <= result_reg;
                        out_free_blk_reg   <= free_blocks_ext[ffba_pkg::COUNT_W-1:0];
                        out_free_bytes_reg <= free_bytes_reg;
                        out_blk_reg        <= used_ext[ffba_pkg::COUNT_W-1:0];
                        out_payload_reg    <= payload_bytes_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// First-fit heap block allocator.
// req: valid/ready channel carrying action (allocate, free, reallocate),
//   request_size and block_address. A transfer happens when valid and
//   ready are both high at a rising edge of clk.
// rsp: one result per request, in order: status, result_address and the
//   running block and byte statistics.
// cfg: register writes (index 0 heap_limit, index 1 max_request), always
//   ready; write only while no request is in flight.
// Each request walks the block table one entry per cycle through the
//   table memory's read port. A reallocate that moves its block walks the
//   table twice, first for its old block and then for a free one; illegal
//   sizes and unknown actions skip the walk. Requests run one at a time
//   through the walker, which takes the next one only after the last result.
// A two-entry command queue sits in front of the table walker, so while a
//   result waits on a stalled receiver up to three more requests are taken
//   (one finished in the walker, two queued) before req.ready drops.
// Reset empties the table and statistics and loads heap_limit = 1048576,
//   max_request = 100000000. No table clearing pass is needed.

module first_fit_block_allocator #(
    parameter int MAX_ENTRIES  = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ffba_cfg_if.sink    cfg,
    ffba_req_if.sink    req,
    ffba_rsp_if.source  rsp
);

    logic [ffba_pkg::BYTES_W-1:0]   heap_limit_reg;
    logic [ffba_pkg::SIZE_W-1:0]    max_request_reg;

    ffba_pkg::ffba_qstat_t          q_stat;
    ffba_pkg::ffba_cmd_t            push_cmd;
    ffba_pkg::ffba_cmd_t            pop_cmd;
    logic                           q_push;
    logic                           q_pop;

    assign cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg  <= ffba_pkg::HEAP_LIMIT_RESET;
            max_request_reg <= ffba_pkg::MAX_REQUEST_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == ffba_pkg::CFG_HEAP_LIMIT)
            begin
                heap_limit_reg <= cfg.data;
            end
            else if (cfg.index == ffba_pkg::CFG_MAX_REQUEST)
            begin
                max_request_reg <= cfg.data[ffba_pkg::SIZE_W-1:0];
            end
        end
    end

    ffba_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .req         (req),
        .max_request (max_request_reg),
        .q_stat      (q_stat),
        .push        (q_push),
        .push_cmd    (push_cmd)
    );

    ffba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    ffba_engine #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .heap_limit (heap_limit_reg),
        .q_stat     (q_stat),
        .pop_cmd    (pop_cmd),
        .pop        (q_pop),
        .rsp        (rsp)
    );

    // A failed request never hands back an address
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ffba_pkg::ST_OK) |-> (rsp.result_address == '0))
        else $error("failed request returned a nonzero address");

    // Free blocks are a subset of all blocks
    a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (MAX_ENTRIES >= 128) || (rsp.free_block_count <= rsp.block_count))
        else $error("free block count exceeds block count");

    // No free blocks means no free bytes
    a_free_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (MAX_ENTRIES < 128) && (rsp.free_block_count == '0)
        |-> (rsp.free_byte_count == '0))
        else $error("free bytes reported with no free blocks");

    // The queue is never pushed when full
    a_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    // A pop without a push leaves the queue with one entry fewer, so not full
    a_q_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_push |=> !q_stat.full)
        else $error("command queue still full after a pop");

endmodule

// ----- sim/first_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

    localparam int TABLE_DEPTH   = 64;
    localparam int HDR_BYTES     = 16;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 24;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Action code the block ignores
    localparam logic [ffba_pkg::ACTION_W-1:0] ACT_NONE   = 2'd3;
    localparam logic [ffba_pkg::SIZE_W-1:0]   SIZE_LIMIT = '1;

    typedef struct packed {
        logic [ffba_pkg::STATUS_W-1:0] status;
        logic [ffba_pkg::ADDR_W-1:0]   result_address;
        logic [ffba_pkg::COUNT_W-1:0]  free_block_count;
        logic [ffba_pkg::BYTES_W-1:0]  free_byte_count;
        logic [ffba_pkg::COUNT_W-1:0]  block_count;
        logic [ffba_pkg::BYTES_W-1:0]  payload_byte_count;
    } alloc_result_t;

    logic clk;
    logic rst_n;

    ffba_cfg_if cfg_bus ();
    ffba_req_if req_bus ();
    ffba_rsp_if rsp_bus ();

    first_fit_block_allocator #(
        .MAX_ENTRIES  (TABLE_DEPTH),
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Heap table as the block should hold it
    logic [ffba_pkg::ADDR_W-1:0]  blk_paddr [TABLE_DEPTH];
    logic [ffba_pkg::SIZE_W-1:0]  blk_size  [TABLE_DEPTH];
    logic                         blk_free  [TABLE_DEPTH];
    int unsigned                  blocks_used     = 0;
    int unsigned                  free_blocks_m   = 0;
    logic [ffba_pkg::BYTES_W-1:0] heap_top_m      = '0;
    logic [ffba_pkg::BYTES_W-1:0] free_bytes_m    = '0;
    logic [ffba_pkg::BYTES_W-1:0] payload_bytes_m = '0;
    logic [ffba_pkg::BYTES_W-1:0] heap_limit_m    = ffba_pkg::HEAP_LIMIT_RESET;
    logic [ffba_pkg::SIZE_W-1:0]  max_request_m   = ffba_pkg::MAX_REQUEST_RESET;

    alloc_result_t awaited_heap_results [$];
    alloc_result_t next_heap_result;

    int unsigned send_idle_pct    = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned hold_off_trigger = 0;
    int unsigned hold_off_seen;
    int unsigned hold_off_left;
    int unsigned cycle_count      = 0;
    int unsigned sent_count       = 0;
    int unsigned error_count      = 0;
    int unsigned status_tally [4] = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Table walk: first entry whose payload address matches
    function automatic int find_block(input logic [ffba_pkg::ADDR_W-1:0] addr);
        for (int i = 0; i < blocks_used; i++)
        begin
            if (blk_paddr[i] == addr)
                return i;
        end
        return -1;
    endfunction

    function automatic void retire_block(input int idx);
        if (!blk_free[idx])
        begin
            blk_free[idx] = 1'b1;
            free_blocks_m++;
            free_bytes_m = free_bytes_m + ffba_pkg::BYTES_W'(blk_size[idx]);
        end
    endfunction

    // First fit without split, else append at the heap top
    function automatic bit grant_block(input logic [ffba_pkg::SIZE_W-1:0] size,
                                       output logic [ffba_pkg::ADDR_W-1:0] addr);
        logic [63:0] end_addr;
        addr = '0;
        for (int i = 0; i < blocks_used; i++)
        begin
            if (blk_free[i] && blk_size[i] >= size)
            begin
                blk_free[i] = 1'b0;
                free_blocks_m--;
                free_bytes_m = free_bytes_m - ffba_pkg::BYTES_W'(blk_size[i]);
                addr = blk_paddr[i];
                return 1'b1;
            end
        end
        end_addr = 64'(heap_top_m) + 64'(size) + 64'(HDR_BYTES);
        if (blocks_used >= TABLE_DEPTH || end_addr > 64'(heap_limit_m))
            return 1'b0;
        blk_paddr[blocks_used] = heap_top_m + ffba_pkg::ADDR_W'(HDR_BYTES);
        blk_size[blocks_used]  = size;
        blk_free[blocks_used]  = 1'b0;
        addr = blk_paddr[blocks_used];
        blocks_used++;
        heap_top_m = end_addr[ffba_pkg::BYTES_W-1:0];
        payload_bytes_m = payload_bytes_m + ffba_pkg::BYTES_W'(size);
        return 1'b1;
    endfunction

    // Advance the heap table by one request and build its result
    function automatic alloc_result_t predict_heap_result(
        input logic [ffba_pkg::ACTION_W-1:0] action,
        input logic [ffba_pkg::SIZE_W-1:0]   size,
        input logic [ffba_pkg::ADDR_W-1:0]   addr);
        alloc_result_t               r;
        int                          idx;
        logic [ffba_pkg::ADDR_W-1:0] granted;
        bit                          bad_size;
        r = '0;
        r.status = ffba_pkg::ST_OK;
        bad_size = (size == '0) || (size > max_request_m);
        case (action)
            ffba_pkg::ACT_ALLOC:
            begin
                if (bad_size)
                    r.status = ffba_pkg::ST_ILLEGAL_SIZE;
                else if (grant_block(size, granted))
                    r.result_address = granted;
                else
                    r.status = ffba_pkg::ST_OUT_OF_MEM;
            end
            ffba_pkg::ACT_FREE:
            begin
                idx = find_block(addr);
                if (idx < 0)
                    r.status = ffba_pkg::ST_UNKNOWN_ADDR;
                else
                    retire_block(idx);
            end
            ffba_pkg::ACT_REALLOC:
            begin
                if (bad_size)
                    r.status = ffba_pkg::ST_ILLEGAL_SIZE;
                else
                begin
                    idx = find_block(addr);
                    if (idx < 0)
                        r.status = ffba_pkg::ST_UNKNOWN_ADDR;
                    else if (blk_size[idx] >= size)
                        r.result_address = addr;
                    else if (!grant_block(size, granted))
                        r.status = ffba_pkg::ST_OUT_OF_MEM;
                    else
                    begin
                        r.result_address = granted;
                        retire_block(idx);
                    end
                end
            end
            default: ;
        endcase
        r.free_block_count   = ffba_pkg::COUNT_W'(free_blocks_m);
        r.free_byte_count    = free_bytes_m;
        r.block_count        = ffba_pkg::COUNT_W'(blocks_used);
        r.payload_byte_count = payload_bytes_m;
        return r;
    endfunction

    // Heap limit that leaves room above the current top, saturated
    function automatic logic [ffba_pkg::BYTES_W-1:0] heap_room(
        input logic [ffba_pkg::BYTES_W-1:0] room);
        if (heap_top_m > ~room)
            return '1;
        return heap_top_m + room;
    endfunction

    function automatic logic [ffba_pkg::SIZE_W-1:0] pick_size();
        int unsigned                 roll;
        logic [ffba_pkg::SIZE_W-1:0] cap;
        roll = $urandom_range(99);
        cap  = max_request_m;
        if (roll < 6)
            return '0;
        if (roll < 12 && cap != SIZE_LIMIT)
            return ffba_pkg::SIZE_W'($urandom_range(SIZE_LIMIT, 32'(cap) + 1));
        if (roll < 80)
            return ffba_pkg::SIZE_W'($urandom_range(cap < 512 ? cap : 512, 1));
        if (roll < 95)
            return ffba_pkg::SIZE_W'($urandom_range(cap < 65536 ? cap : 65536, 1));
        return ffba_pkg::SIZE_W'($urandom_range(cap, 1));
    endfunction

    // Mostly live blocks, some near misses and random noise
    function automatic logic [ffba_pkg::ADDR_W-1:0] pick_address();
        int unsigned roll;
        roll = $urandom_range(99);
        if (blocks_used == 0 || roll < 10)
            return $urandom();
        if (roll < 16)
            return blk_paddr[$urandom_range(blocks_used - 1)] + 32'd1;
        return blk_paddr[$urandom_range(blocks_used - 1)];
    endfunction

    // Offer one request after a random gap; predict it on transfer
    task automatic send_request(input logic [ffba_pkg::ACTION_W-1:0] action,
                                input logic [ffba_pkg::SIZE_W-1:0]   size,
                                input logic [ffba_pkg::ADDR_W-1:0]   addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.action        <= action;
        req_bus.request_size  <= size;
        req_bus.block_address <= addr;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
        awaited_heap_results.push_back(predict_heap_result(action, size, addr));
        sent_count++;
    endtask

    task automatic random_request();
        int unsigned                   roll;
        int unsigned                   idx;
        int unsigned                   grow_cap;
        logic [ffba_pkg::ACTION_W-1:0] action;
        logic [ffba_pkg::SIZE_W-1:0]   size;
        logic [ffba_pkg::ADDR_W-1:0]   addr;
        roll   = $urandom_range(99);
        size   = pick_size();
        addr   = pick_address();
        action = ACT_NONE;
        if (roll < 42)
            action = ffba_pkg::ACT_ALLOC;
        else if (roll < 68)
            action = ffba_pkg::ACT_FREE;
        else if (roll < 95)
        begin
            action = ffba_pkg::ACT_REALLOC;
            // Half the time resize a live block around its current size
            if (blocks_used != 0 && $urandom_range(1) == 1)
            begin
                idx      = $urandom_range(blocks_used - 1);
                addr     = blk_paddr[idx];
                grow_cap = 2 * blk_size[idx];
                if (grow_cap > max_request_m)
                    grow_cap = max_request_m;
                size = ffba_pkg::SIZE_W'($urandom_range(grow_cap, 1));
            end
        end
        send_request(action, size, addr);
    endtask

    // Drop the request valid and hold until every result is back
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        while (awaited_heap_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back, valid held across the transfers
    task automatic write_limits(input logic [ffba_pkg::BYTES_W-1:0] heap,
                                input logic [ffba_pkg::SIZE_W-1:0]  max_req);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= ffba_pkg::CFG_HEAP_LIMIT;
        cfg_bus.data  <= heap;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        heap_limit_m = heap;
        cfg_bus.index <= ffba_pkg::CFG_MAX_REQUEST;
        cfg_bus.data  <= ffba_pkg::CFG_DATA_W'(max_req);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        max_request_m = max_req;
        cfg_bus.valid <= 1'b0;
    endtask

    // Size checks, reuse, free twice, reallocate in place and by move
    task automatic test_directed_requests();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        send_request(ffba_pkg::ACT_ALLOC, '0, '0);
        send_request(ffba_pkg::ACT_ALLOC,
                     ffba_pkg::MAX_REQUEST_RESET + ffba_pkg::SIZE_W'(1), '0);
        send_request(ffba_pkg::ACT_ALLOC, ffba_pkg::MAX_REQUEST_RESET, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd100, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd200, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd50, '0);
        send_request(ffba_pkg::ACT_FREE, '0, blk_paddr[0]);
        send_request(ffba_pkg::ACT_FREE, '0, blk_paddr[0]);
        send_request(ffba_pkg::ACT_ALLOC, 27'd80, '0);
        send_request(ffba_pkg::ACT_FREE, '0, '0);
        send_request(ffba_pkg::ACT_FREE, '0, blk_paddr[1]);
        // free block that is big enough stays free
        send_request(ffba_pkg::ACT_REALLOC, 27'd150, blk_paddr[1]);
        send_request(ffba_pkg::ACT_REALLOC, 27'd300, blk_paddr[2]);
        // free block that moves stays free
        send_request(ffba_pkg::ACT_REALLOC, 27'd500, blk_paddr[1]);
        send_request(ffba_pkg::ACT_REALLOC, 27'd2000000, blk_paddr[0]);
        send_request(ffba_pkg::ACT_REALLOC, 27'd10, '1);
        // size is checked before the address
        send_request(ffba_pkg::ACT_REALLOC, '0, '1);
        send_request(ACT_NONE, ffba_pkg::SIZE_W'($urandom()), blk_paddr[0]);
    endtask

    // Smallest and largest register settings
    task automatic test_register_extremes();
        wait_for_results();
        write_limits('0, 27'd1);
        send_request(ffba_pkg::ACT_ALLOC, 27'd1, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd2, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd1, '0);
        send_request(ffba_pkg::ACT_ALLOC, 27'd1, '0);
        send_request(ffba_pkg::ACT_REALLOC, 27'd1, blk_paddr[3]);
        wait_for_results();
        write_limits('1, SIZE_LIMIT);
        send_request(ffba_pkg::ACT_ALLOC, SIZE_LIMIT, '0);
        send_request(ffba_pkg::ACT_ALLOC, SIZE_LIMIT, '0);
        send_request(ffba_pkg::ACT_REALLOC, SIZE_LIMIT, blk_paddr[5]);
    endtask

    task automatic test_random_traffic(input int unsigned                  items,
                                       input int unsigned                  send_pct,
                                       input int unsigned                  stall_pct,
                                       input logic [ffba_pkg::BYTES_W-1:0] heap,
                                       input logic [ffba_pkg::SIZE_W-1:0]  max_req);
        wait_for_results();
        write_limits(heap, max_req);
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
        repeat (items)
            random_request();
    endtask

    // Hold off the receiver while requests keep coming, so the block fills
    task automatic test_backpressure();
        wait_for_results();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_off_trigger <= hold_off_trigger + 1;
        repeat (30)
            random_request();
    endtask

    // Result receiver: random stalls plus an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            hold_off_seen <= 0;
            hold_off_left <= 0;
        end
        else if (hold_off_trigger != hold_off_seen)
        begin
            hold_off_seen <= hold_off_trigger;
            hold_off_left <= HOLD_OFF_LEN;
            rsp_bus.ready <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void compare_field(input string name,
                                          input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (awaited_heap_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d address %0h",
                         $time, rsp_bus.status, rsp_bus.result_address);
                error_count++;
            end
            else
            begin
                next_heap_result = awaited_heap_results.pop_front();
                compare_field("status", 32'(next_heap_result.status),
                              32'(rsp_bus.status));
                compare_field("result_address", next_heap_result.result_address,
                              rsp_bus.result_address);
                compare_field("free_block_count", 32'(next_heap_result.free_block_count),
                              32'(rsp_bus.free_block_count));
                compare_field("free_byte_count", next_heap_result.free_byte_count,
                              rsp_bus.free_byte_count);
                compare_field("block_count", 32'(next_heap_result.block_count),
                              32'(rsp_bus.block_count));
                compare_field("payload_byte_count", next_heap_result.payload_byte_count,
                              rsp_bus.payload_byte_count);
                status_tally[next_heap_result.status]++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_heap_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.action        <= ffba_pkg::ACT_ALLOC;
        req_bus.request_size  <= '0;
        req_bus.block_address <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= ffba_pkg::CFG_HEAP_LIMIT;
        cfg_bus.data          <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_register_extremes();
        test_random_traffic(100, 0, 0, heap_room(32'd1048576),
                            ffba_pkg::MAX_REQUEST_RESET);
        test_random_traffic(100, 56, 0, heap_room(32'd262144), 27'd4096);
        test_random_traffic(100, 0, 56, '1, SIZE_LIMIT);
        test_random_traffic(100, 6, 6, heap_room(32'd65536),
                            ffba_pkg::MAX_REQUEST_RESET);
        test_backpressure();

        // Drain, then let the block settle before closing
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display({"Ran %0d requests in %0d cycles: %0d ok, %0d illegal size, ",
                  "%0d out of memory, %0d unknown address"},
                 sent_count, cycle_count, status_tally[ffba_pkg::ST_OK],
                 status_tally[ffba_pkg::ST_ILLEGAL_SIZE],
                 status_tally[ffba_pkg::ST_OUT_OF_MEM],
                 status_tally[ffba_pkg::ST_UNKNOWN_ADDR]);
        $display("Heap table ended with %0d blocks, %0d free; %0d field mismatches",
                 blocks_used, free_blocks_m, error_count);
        if (error_count == 0 && awaited_heap_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
